@@ hdl/fqd_pkg.sv @@
// Shared types and constants for the queue with delete-by-value.
// Used by fqd_store and fifo_queue_with_delete. No dependencies.
package fqd_pkg;

  // Request codes
  localparam logic [1:0] REQ_ENQ = 2'd0;
  localparam logic [1:0] REQ_DEQ = 2'd1;
  localparam logic [1:0] REQ_DEL = 2'd2;

  // Status codes
  localparam logic STATUS_OK     = 1'b0;
  localparam logic STATUS_REJECT = 1'b1;

  // Control from the sequencer to the entry store
  typedef struct packed {
    logic rd_en;  // read the entry at rd_idx, data next cycle
    logic wr_en;  // write wr_data at wr_idx
    logic pop;    // advance the head past the oldest entry
  } store_ctl_t;

endpackage

@@ hdl/fqd_store.sv @@
// Entry store: a ring of DEPTH entries in one synchronous memory,
// addressed by position from the oldest entry. Depends on fqd_pkg.
module fqd_store #(
  parameter int DEPTH       = 16,
  parameter int VALUE_WIDTH = 32
) (
  input  logic                     clk,
  input  logic                     rst,
  input  fqd_pkg::store_ctl_t      ctl,
  input  logic [$clog2(DEPTH)-1:0] rd_idx,
  input  logic [$clog2(DEPTH)-1:0] wr_idx,
  input  logic [VALUE_WIDTH-1:0]   wr_data,
  output logic [VALUE_WIDTH-1:0]   rd_data
);

  localparam int IDX_W = $clog2(DEPTH);
  localparam logic [IDX_W:0] DEPTH_L = (IDX_W + 1)'(DEPTH);

  logic [VALUE_WIDTH-1:0] mem [DEPTH];
  logic [IDX_W-1:0]       head;
  logic [IDX_W:0]         rd_sum;
  logic [IDX_W:0]         wr_sum;
  logic [IDX_W:0]         head_inc;
  logic [IDX_W-1:0]       rd_phys;
  logic [IDX_W-1:0]       wr_phys;
  logic [IDX_W-1:0]       head_next;

  // Map position to slot: the sum stays below twice the depth
  always_comb begin
    rd_sum    = {1'b0, head} + {1'b0, rd_idx};
    wr_sum    = {1'b0, head} + {1'b0, wr_idx};
    head_inc  = {1'b0, head} + (IDX_W + 1)'(1);
    rd_phys   = (rd_sum >= DEPTH_L) ? IDX_W'(rd_sum - DEPTH_L) : rd_sum[IDX_W-1:0];
    wr_phys   = (wr_sum >= DEPTH_L) ? IDX_W'(wr_sum - DEPTH_L) : wr_sum[IDX_W-1:0];
    head_next = (head_inc == DEPTH_L) ? '0 : head_inc[IDX_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      head <= '0;
    end else if (ctl.pop) begin
      head <= head_next;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.wr_en) begin
      mem[wr_phys] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.rd_en) begin
      rd_data <= mem[rd_phys];
    end
  end

endmodule

@@ hdl/fifo_queue_with_delete.sv @@
// Top level of the bounded queue with delete-by-value: request sequencer
// and result register. Depends on fqd_pkg and fqd_store.
//
// Usage:
//   Requests come in on the input channel (in_valid/in_ready) as req_type
//   and value_in; each gives exactly one result on the output channel
//   (out_valid/out_ready) carrying status, value_out and count.
//   One request is worked on at a time; in_ready is high only while the
//   sequencer is idle.
// Path of a request from the input transfer to the output register:
//   enqueue, unused code, and dequeue or delete refused up front: done state
//   dequeue: one memory read, then the done state
//   delete that scans, matched or not: each entry held before it is read and
//   checked in turn (read state, then check state), and later entries shift
//   down one place through the write port as it goes.
// The next request is taken as soon as the result sits in the output
// register, even if the receiver has not yet taken it. If the receiver
// stalls, a finished result holds in the sequencer until the output register
// frees, and no request is taken.
// Reset empties the queue (occupancy to zero, head to slot 0) and drops any
// result in flight. Entry contents are not cleared; only entries written
// since are ever read.
module fifo_queue_with_delete #(
  parameter int DEPTH       = 16,
  parameter int VALUE_WIDTH = 32
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic [1:0]                   req_type,
  input  logic [VALUE_WIDTH-1:0]       value_in,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic                         status,
  output logic [VALUE_WIDTH-1:0]       value_out,
  output logic [$clog2(DEPTH+1)-1:0]   count
);

  localparam int IDX_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam logic [CNT_W-1:0] DEPTH_C = CNT_W'(DEPTH);

  // Sequencer states
  localparam logic [2:0] S_IDLE     = 3'd0;
  localparam logic [2:0] S_DEQ_DATA = 3'd1;
  localparam logic [2:0] S_SCAN_RD  = 3'd2;
  localparam logic [2:0] S_SCAN_CHK = 3'd3;
  localparam logic [2:0] S_DONE     = 3'd4;

  logic [2:0]             state, state_next;
  logic [CNT_W-1:0]       occ, occ_next;
  logic [IDX_W-1:0]       idx, idx_next;
  logic                   found, found_next;
  logic [VALUE_WIDTH-1:0] req_val, req_val_next;
  logic                   res_status, res_status_next;
  logic [VALUE_WIDTH-1:0] res_value, res_value_next;
  logic                   out_free;
  logic                   load_out;
  logic [CNT_W-1:0]       idx_inc;

  fqd_pkg::store_ctl_t    ctl;
  logic [IDX_W-1:0]       rd_idx;
  logic [IDX_W-1:0]       wr_idx;
  logic [VALUE_WIDTH-1:0] wr_data;
  logic [VALUE_WIDTH-1:0] rd_data;

  fqd_store #(
    .DEPTH       (DEPTH),
    .VALUE_WIDTH (VALUE_WIDTH)
  ) u_store (
    .clk     (clk),
    .rst     (rst),
    .ctl     (ctl),
    .rd_idx  (rd_idx),
    .wr_idx  (wr_idx),
    .wr_data (wr_data),
    .rd_data (rd_data)
  );

  assign in_ready = (state == S_IDLE);
  assign out_free = !out_valid || out_ready;
  assign load_out = (state == S_DONE) && out_free;
  assign idx_inc  = CNT_W'(idx) + CNT_W'(1);

  always_comb begin
    state_next      = state;
    occ_next        = occ;
    idx_next        = idx;
    found_next      = found;
    req_val_next    = req_val;
    res_status_next = res_status;
    res_value_next  = res_value;
    ctl             = '0;
    rd_idx          = idx;
    wr_idx          = occ[IDX_W-1:0];
    wr_data         = req_val;

    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          req_val_next    = value_in;
          res_value_next  = '0;
          res_status_next = fqd_pkg::STATUS_REJECT;
          state_next      = S_DONE;
          priority if (req_type == fqd_pkg::REQ_ENQ) begin
            // Append at the tail
            if (value_in != '0 && occ < DEPTH_C) begin
              ctl.wr_en       = 1'b1;
              wr_idx          = occ[IDX_W-1:0];
              wr_data         = value_in;
              occ_next        = occ + CNT_W'(1);
              res_status_next = fqd_pkg::STATUS_OK;
            end
          end else if (req_type == fqd_pkg::REQ_DEQ) begin
            // Read the oldest entry and advance the head at once
            if (occ != '0) begin
              ctl.rd_en  = 1'b1;
              ctl.pop    = 1'b1;
              rd_idx     = '0;
              occ_next   = occ - CNT_W'(1);
              state_next = S_DEQ_DATA;
            end
          end else if (req_type == fqd_pkg::REQ_DEL) begin
            if (occ != '0 && value_in != '0) begin
              idx_next   = '0;
              found_next = 1'b0;
              state_next = S_SCAN_RD;
            end
          end else begin
            res_status_next = fqd_pkg::STATUS_REJECT;
          end
        end
      end

      S_DEQ_DATA: begin
        res_value_next  = rd_data;
        res_status_next = fqd_pkg::STATUS_OK;
        state_next      = S_DONE;
      end

      S_SCAN_RD: begin
        ctl.rd_en  = 1'b1;
        rd_idx     = idx;
        state_next = S_SCAN_CHK;
      end

      S_SCAN_CHK: begin
        // After the match, move each later entry down one place
        if (found) begin
          ctl.wr_en = 1'b1;
          wr_idx    = idx - IDX_W'(1);
          wr_data   = rd_data;
        end else if (rd_data == req_val) begin
          found_next = 1'b1;
        end
        if (idx_inc == occ) begin
          if (found || rd_data == req_val) begin
            occ_next        = occ - CNT_W'(1);
            res_status_next = fqd_pkg::STATUS_OK;
          end else begin
            res_status_next = fqd_pkg::STATUS_REJECT;
          end
          state_next = S_DONE;
        end else begin
          idx_next   = idx_inc[IDX_W-1:0];
          state_next = S_SCAN_RD;
        end
      end

      S_DONE: begin
        // Hold the result until the output register frees
        if (out_free) begin
          state_next = S_IDLE;
        end
      end

      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      occ       <= '0;
      found     <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      occ   <= occ_next;
      found <= found_next;
      if (load_out) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Payload registers: no reset needed
  always_ff @(posedge clk) begin
    idx        <= idx_next;
    req_val    <= req_val_next;
    res_status <= res_status_next;
    res_value  <= res_value_next;
    if (load_out) begin
      status    <= res_status;
      value_out <= res_value;
      count     <= occ;
    end
  end

endmodule

@@ tb/sv/tb.sv @@
// Self-checking testbench for fifo_queue_with_delete: a table of directed requests,
// then random enqueue, dequeue and delete traffic with random gaps on both channels.
// Depends on fqd_pkg and the fifo_queue_with_delete RTL.
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int DEPTH = 16;
  localparam int VW = 32;
  localparam int CW = $clog2(DEPTH + 1);

  // The request code that the package leaves unused; the block must reject it
  localparam logic [1:0] REQ_UNUSED = 2'd3;

  localparam int RAND_SEGMENTS = 8;
  localparam int SEG_ITEMS     = 50;
  localparam int POOL_SIZE     = 6;
  localparam int LONG_HOLD     = 200;
  localparam int IDLE_LIMIT    = 3000;
  localparam int TAIL_CYCLES   = 40;

  typedef struct packed {
    logic          st;
    logic [VW-1:0] vout;
    logic [CW-1:0] cnt;
  } queue_result_t;

  // One row of the directed table. A row with reps above one offers the same
  // request that many times, with the value stepping up by one each time.
  typedef struct packed {
    logic [1:0]    req;
    logic [VW-1:0] val;
    logic [4:0]    reps;
    logic          typed;
    queue_result_t res;
  } dir_row_t;

  localparam int DIR_ROWS = 18;
  localparam dir_row_t DIR_TABLE [0:DIR_ROWS-1] = '{
    // Rejections on the empty queue straight after reset
    '{fqd_pkg::REQ_DEQ, 32'h0000_0000, 5'd1, 1'b1, '{fqd_pkg::STATUS_REJECT, 32'h0, 5'd0}},
    '{fqd_pkg::REQ_DEL, 32'h0000_0005, 5'd1, 1'b1, '{fqd_pkg::STATUS_REJECT, 32'h0, 5'd0}},
    '{fqd_pkg::REQ_ENQ, 32'h0000_0000, 5'd1, 1'b1, '{fqd_pkg::STATUS_REJECT, 32'h0, 5'd0}},
    '{REQ_UNUSED,       32'hFFFF_FFFF, 5'd1, 1'b1, '{fqd_pkg::STATUS_REJECT, 32'h0, 5'd0}},
    // Largest and smallest handles
    '{fqd_pkg::REQ_ENQ, 32'hFFFF_FFFF, 5'd1, 1'b1, '{fqd_pkg::STATUS_OK, 32'h0, 5'd1}},
    '{fqd_pkg::REQ_ENQ, 32'h0000_0001, 5'd1, 1'b1, '{fqd_pkg::STATUS_OK, 32'h0, 5'd2}},
    // Delete of zero, delete with no match, unused code with entries held, a dequeue
    '{fqd_pkg::REQ_DEL, 32'h0000_0000, 5'd1, 1'b1, '{fqd_pkg::STATUS_REJECT, 32'h0, 5'd2}},
    '{fqd_pkg::REQ_DEL, 32'h5555_5555, 5'd1, 1'b1, '{fqd_pkg::STATUS_REJECT, 32'h0, 5'd2}},
    '{REQ_UNUSED,       32'hAAAA_AAAA, 5'd1, 1'b1, '{fqd_pkg::STATUS_REJECT, 32'h0, 5'd2}},
    '{fqd_pkg::REQ_DEQ, 32'h0000_0000, 5'd1, 1'b1, '{fqd_pkg::STATUS_OK, 32'hFFFF_FFFF, 5'd1}},
    // Fill to the brim, then one enqueue too many
    '{fqd_pkg::REQ_ENQ, 32'h8000_0000, 5'd15, 1'b0, '0},
    '{fqd_pkg::REQ_ENQ, 32'h7FFF_FFFF, 5'd1, 1'b1, '{fqd_pkg::STATUS_REJECT, 32'h0, 5'd16}},
    // Delete from the middle, then duplicates: the oldest copy must go first
    '{fqd_pkg::REQ_DEL, 32'h8000_0007, 5'd1, 1'b0, '0},
    '{fqd_pkg::REQ_ENQ, 32'h0000_0001, 5'd1, 1'b0, '0},
    '{fqd_pkg::REQ_DEL, 32'h0000_0001, 5'd1, 1'b0, '0},
    '{fqd_pkg::REQ_DEL, 32'h0000_0001, 5'd1, 1'b0, '0},
    '{fqd_pkg::REQ_DEL, 32'h0000_0001, 5'd1, 1'b1, '{fqd_pkg::STATUS_REJECT, 32'h0, 5'd14}},
    '{fqd_pkg::REQ_DEQ, 32'h0000_0000, 5'd1, 1'b0, '0}
  };

  logic          clk = 1'b0;
  logic          rst;
  logic          in_valid;
  logic          in_ready;
  logic [1:0]    req_type;
  logic [VW-1:0] value_in;
  logic          out_valid;
  logic          out_ready;
  logic          status;
  logic [VW-1:0] value_out;
  logic [CW-1:0] count;

  // Shadow copy of the queue contents, slot 0 the oldest
  logic [VW-1:0] shadow_q [$];
  queue_result_t pending_results [$];
  logic [VW-1:0] value_pool [POOL_SIZE];

  int  fail_count;
  int  n_requests, n_enq_ok, n_deq_ok, n_del_hit;
  int  n_full_rej, n_empty_rej, n_other_rej;
  int  idle_cycles;
  int  n_long_holds;
  bit  stall_req;
  bit  rx_gaps_on;

  always #4 clk = ~clk;

  fifo_queue_with_delete #(
    .DEPTH      (DEPTH),
    .VALUE_WIDTH(VW)
  ) u_top (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .req_type (req_type),
    .value_in (value_in),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .status   (status),
    .value_out(value_out),
    .count    (count)
  );

  // Advance the shadow queue by one request and return the result it must give.
  // A rejected request leaves the shadow untouched.
  function automatic queue_result_t queue_step(input logic [1:0] req, input logic [VW-1:0] val);
    queue_result_t res;
    int            hit;
    res.st   = fqd_pkg::STATUS_REJECT;
    res.vout = '0;
    hit      = -1;
    case (req)
      fqd_pkg::REQ_ENQ: begin
        if (val != '0 && shadow_q.size() < DEPTH) begin
          shadow_q.push_back(val);
          res.st = fqd_pkg::STATUS_OK;
          n_enq_ok++;
        end else if (val != '0) begin
          n_full_rej++;
        end
      end
      fqd_pkg::REQ_DEQ: begin
        if (shadow_q.size() > 0) begin
          res.vout = shadow_q.pop_front();
          res.st   = fqd_pkg::STATUS_OK;
          n_deq_ok++;
        end else begin
          n_empty_rej++;
        end
      end
      fqd_pkg::REQ_DEL: begin
        if (val != '0) begin
          foreach (shadow_q[i]) begin
            if (hit < 0 && shadow_q[i] == val) hit = i;
          end
        end
        if (hit >= 0) begin
          shadow_q.delete(hit);
          res.st = fqd_pkg::STATUS_OK;
          n_del_hit++;
        end else if (shadow_q.size() == 0) begin
          n_empty_rej++;
        end
      end
      default: ;
    endcase
    if (res.st == fqd_pkg::STATUS_REJECT) n_other_rej++;
    res.cnt = CW'(shadow_q.size());
    return res;
  endfunction

  // Mostly no gap, often a short one, now and then a long one
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 10);
    return $urandom_range(11, 40);
  endfunction

  // Offer one request and hold it until the transfer; record what it must give.
  // Called at a rising edge; returns at the edge of the transfer with in_valid still high.
  task automatic offer(input logic [1:0] req, input logic [VW-1:0] val, input logic typed,
                       input queue_result_t typed_res);
    queue_result_t res;
    in_valid <= 1'b1;
    req_type <= req;
    value_in <= val;
    do @(posedge clk); while (!(in_valid && in_ready));
    res = queue_step(req, val);
    pending_results.push_back(typed ? typed_res : res);
    n_requests++;
  endtask

  // Drop valid and wait until every outstanding result has been taken
  task automatic drain();
    in_valid <= 1'b0;
    do @(posedge clk); while (pending_results.size() != 0);
  endtask

  // Sender: reset, directed table, then random segments
  initial begin
    logic [1:0]    req;
    logic [VW-1:0] val;
    int            r, gap;
    bit            fill, gaps_on;

    rst        = 1'b1;
    in_valid   = 1'b0;
    req_type   = fqd_pkg::REQ_ENQ;
    value_in   = '0;
    stall_req  = 1'b0;
    rx_gaps_on = 1'b0;
    fail_count = 0;
    foreach (value_pool[k]) begin
      value_pool[k] = $urandom();
      if (value_pool[k] == '0) value_pool[k] = VW'(1);
    end

    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Walk the directed table, back to back
    for (int row = 0; row < DIR_ROWS; row++) begin
      for (int k = 0; k < DIR_TABLE[row].reps; k++) begin
        offer(DIR_TABLE[row].req, DIR_TABLE[row].val + VW'(k), DIR_TABLE[row].typed,
              DIR_TABLE[row].res);
      end
    end
    drain();

    // Random part: segments alternate between filling and draining bias.
    // Segments 0,1 and 4,5 run with no idling; the rest idle at random on both sides.
    for (int seg = 0; seg < RAND_SEGMENTS; seg++) begin
      fill       = (seg % 2) == 0;
      gaps_on    = (seg % 4) >= 2;
      rx_gaps_on = gaps_on;
      // Hold the output off for a long stretch while requests keep coming
      if (seg == 2) stall_req = 1'b1;
      for (int i = 0; i < SEG_ITEMS; i++) begin
        r = $urandom_range(0, 99);
        if (r < 2) req = REQ_UNUSED;
        else if (r < (fill ? 62 : 27)) req = fqd_pkg::REQ_ENQ;
        else if (r < (fill ? 82 : 67)) req = fqd_pkg::REQ_DEQ;
        else req = fqd_pkg::REQ_DEL;

        // Deletes mostly aim at a value that is held; the small pool makes duplicates
        r = $urandom_range(0, 99);
        if (req == fqd_pkg::REQ_DEL && shadow_q.size() > 0 && r < 50)
          val = shadow_q[$urandom_range(0, shadow_q.size() - 1)];
        else if (r < 8) val = '0;
        else if (r < 30) val = $urandom();
        else val = value_pool[$urandom_range(0, POOL_SIZE - 1)];

        offer(req, val, 1'b0, '0);
        gap = gaps_on ? pick_gap() : 0;
        if (gap > 0) begin
          in_valid <= 1'b0;
          repeat (gap) @(posedge clk);
        end
      end
      // Pause the sender until every result of the segment is in
      drain();
    end

    rx_gaps_on = 1'b0;
    repeat (TAIL_CYCLES) @(posedge clk);
    if (pending_results.size() != 0) begin
      fail_count++;
      $display("%0d results never arrived", pending_results.size());
    end

    $display("covered %0d requests: %0d enqueues, %0d dequeues, %0d deletes succeeded",
             n_requests, n_enq_ok, n_deq_ok, n_del_hit);
    $display("rejections: %0d on full, %0d on empty, %0d in all; %0d long output stalls",
             n_full_rej, n_empty_rej, n_other_rej, n_long_holds);
    if (fail_count == 0) begin
      $display("tb passed");
    end else begin
      $display("tb failed");
    end
    $finish;
  end

  // Receiver: random back-pressure, plus one long hold on request
  initial begin
    int hold;
    out_ready    = 1'b0;
    hold         = 0;
    n_long_holds = 0;
    forever begin
      @(posedge clk);
      if (stall_req) begin
        stall_req = 1'b0;
        hold      = LONG_HOLD;
        n_long_holds++;
      end
      if (hold > 0) begin
        out_ready <= 1'b0;
        hold--;
      end else if (rx_gaps_on && $urandom_range(0, 99) < 30) begin
        out_ready <= 1'b0;
        hold      = pick_gap();
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  // Compare each result transfer with the oldest outstanding expectation
  always @(posedge clk) begin
    queue_result_t want;
    if (!rst && out_valid && out_ready) begin
      if (pending_results.size() == 0) begin
        fail_count++;
        if (fail_count <= 10)
          $display("result with nothing outstanding: status %0b value_out %h count %0d",
                   status, value_out, count);
      end else begin
        want = pending_results.pop_front();
        if (status !== want.st || value_out !== want.vout || count !== want.cnt) begin
          fail_count++;
          if (fail_count <= 10)
            $display("mismatch: status %0b/%0b value_out %h/%h count %0d/%0d (exp/got)",
                     want.st, status, want.vout, value_out, want.cnt, count);
        end
      end
    end
  end

  // Watchdog: end the run if neither channel transfers for too long
  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("no transfer for %0d cycles", IDLE_LIMIT);
      $display("tb failed");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

endmodule
